// ===== hdl/http_request_line_matcher_defines.svh =====
// Assertion helpers for the matcher RTL, included by hrlm_back.
`ifndef HTTP_REQUEST_LINE_MATCHER_DEFINES_SVH
`define HTTP_REQUEST_LINE_MATCHER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define HRLM_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define HRLM_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/hrlm_pkg.sv =====
package hrlm_pkg;

   localparam int DEF_MAX_PAYLOAD = 1024;
   localparam int DEF_MID_DEPTH   = 2;
   localparam int DEF_OUT_DEPTH   = 2;

   localparam int CSR_ADDR_W = 6;
   localparam int CSR_DATA_W = 64;
   localparam int OUT_W      = 11;
   localparam int PAT_WORDS  = 4;
   localparam int PAT_BYTES  = 8 * PAT_WORDS;

   localparam logic [3:0] METHOD_LEN_MAX = 4'd8;

   localparam logic [63:0] RST_METHOD_CHARS = 64'd5522759;
   localparam logic [3:0]  RST_METHOD_LEN   = 4'd3;
   localparam logic [63:0] RST_PATTERN0     = 64'd47;

   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_QMARK = 8'h3F;
   localparam logic [7:0] CH_HASH  = 8'h23;
   localparam logic [7:0] CH_NL    = 8'h0A;
   localparam logic [7:0] CH_NUL   = 8'h00;

   typedef enum logic [2:0] {
      REG_METHOD_CHARS = 3'd0,
      REG_METHOD_LEN   = 3'd1,
      REG_PATTERN0     = 3'd2,
      REG_PATTERN1     = 3'd3,
      REG_PATTERN2     = 3'd4,
      REG_PATTERN3     = 3'd5
   } reg_idx_type;

   typedef enum logic [2:0] {
      PH_HEAD = 3'b001,
      PH_PATH = 3'b010,
      PH_REST = 3'b100
   } phase_type;

   typedef struct packed {
      logic [63:0]                  method_chars;
      logic [3:0]                   method_len;
      logic [PAT_WORDS-1:0][63:0]   pattern;
   } cfg_type;

   // Classified byte handed from front to back.
   typedef struct packed {
      logic last;
      logic in_range;
      logic at_head;
      logic at_space;
      logic meth_bad;
      logic sp_bad;
      logic is_term;
      logic p_zero;
      logic p_hash;
      logic p_qmark;
      logic b_ne_p;
      logic is_nl;
      logic body_win;
   } tok_type;

   typedef struct packed {
      logic             matched;
      logic [OUT_W-1:0] path_length;
      logic             body_found;
      logic [OUT_W-1:0] body_offset;
      logic [OUT_W-1:0] body_length;
   } rsp_type;

endpackage

// ===== hdl/hrlm_csr.sv =====
module hrlm_csr import hrlm_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   output cfg_type               cfg
);

   logic [63:0]                method_chars_ff;
   logic [3:0]                 method_len_ff;
   logic [PAT_WORDS-1:0][63:0] pattern_ff;
   logic                       wr_en;
   logic [2:0]                 reg_idx;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign reg_idx    = csr_paddr[5:3];

   always_ff @(posedge clock) begin
      if (reset) begin
         method_chars_ff <= RST_METHOD_CHARS;
         method_len_ff   <= RST_METHOD_LEN;
         pattern_ff      <= {{((PAT_WORDS-1)*64){1'b0}}, RST_PATTERN0};
      end else if (wr_en) begin
         unique case (reg_idx)
            REG_METHOD_CHARS: method_chars_ff <= csr_pwdata;
            REG_METHOD_LEN:   method_len_ff   <= csr_pwdata[3:0];
            REG_PATTERN0:     pattern_ff[0]   <= csr_pwdata;
            REG_PATTERN1:     pattern_ff[1]   <= csr_pwdata;
            REG_PATTERN2:     pattern_ff[2]   <= csr_pwdata;
            REG_PATTERN3:     pattern_ff[3]   <= csr_pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         REG_METHOD_CHARS: csr_prdata = method_chars_ff;
         REG_METHOD_LEN:   csr_prdata = {60'd0, method_len_ff};
         REG_PATTERN0:     csr_prdata = pattern_ff[0];
         REG_PATTERN1:     csr_prdata = pattern_ff[1];
         REG_PATTERN2:     csr_prdata = pattern_ff[2];
         REG_PATTERN3:     csr_prdata = pattern_ff[3];
         default:          csr_prdata = '0;
      endcase
   end

   assign cfg.method_chars = method_chars_ff;
   assign cfg.method_len   = method_len_ff;
   assign cfg.pattern      = pattern_ff;

endmodule

// ===== hdl/hrlm_front.sv =====
module hrlm_front import hrlm_pkg::*; #(
   parameter int MAX_PAYLOAD = DEF_MAX_PAYLOAD,
   localparam int POS_W = $clog2(MAX_PAYLOAD + 1)
) (
   input  logic             clock,
   input  logic             reset,
   input  cfg_type          cfg,
   input  logic             req_push,
   output logic             req_full,
   input  logic [7:0]       req_data_byte,
   input  logic             req_last_byte,
   input  logic             mid_full,
   output logic             mid_push,
   output tok_type          tok,
   output logic [POS_W-1:0] len
);

   localparam logic [POS_W:0] MAX_W = (POS_W + 1)'(MAX_PAYLOAD);

   logic [POS_W-1:0]         pos_ff, pos_in;
   logic [POS_W:0]           pos_inc;
   logic [3:0]               mlen;
   logic [POS_W-1:0]         mlen_w;
   logic [POS_W-1:0]         pat_idx;
   logic [PAT_BYTES*8-1:0]   pat_flat;
   logic [PAT_BYTES-1:0]     pat_live;
   logic                     run;
   logic [7:0]               pat_raw;
   logic [7:0]               pat_byte;
   logic [7:0]               meth_char;

   assign req_full = mid_full;
   assign mid_push = req_push & ~mid_full;

   assign mlen    = (cfg.method_len > METHOD_LEN_MAX) ? METHOD_LEN_MAX : cfg.method_len;
   assign mlen_w  = POS_W'(mlen);
   assign pos_inc = {1'b0, pos_ff} + 1'b1;

   // A pattern byte counts only while no zero byte came before it.
   assign pat_flat = cfg.pattern;
   always_comb begin
      run = 1'b1;
      for (int j = 0; j < PAT_BYTES; j++) begin
         run         = run & (pat_flat[8*j +: 8] != CH_NUL);
         pat_live[j] = run;
      end
   end

   assign pat_idx  = pos_ff - mlen_w - POS_W'(1);
   assign pat_raw  = pat_flat[8*pat_idx[4:0] +: 8];
   assign pat_byte = (({1'b0, pat_idx} >= (POS_W + 1)'(PAT_BYTES)) || !pat_live[pat_idx[4:0]])
                     ? CH_NUL : pat_raw;
   assign meth_char = cfg.method_chars[8*pos_ff[2:0] +: 8];

   always_comb begin
      tok.last     = req_last_byte;
      tok.in_range = ({1'b0, pos_ff} < MAX_W);
      tok.at_head  = pos_ff < mlen_w;
      tok.at_space = pos_ff == mlen_w;
      tok.meth_bad = req_data_byte != meth_char;
      tok.sp_bad   = req_data_byte != CH_SPACE;
      tok.is_term  = (req_data_byte == CH_SPACE) || (req_data_byte == CH_TAB)
                     || (req_data_byte == CH_QMARK);
      tok.p_zero   = pat_byte == CH_NUL;
      tok.p_hash   = pat_byte == CH_HASH;
      tok.p_qmark  = pat_byte == CH_QMARK;
      tok.b_ne_p   = req_data_byte != pat_byte;
      tok.is_nl    = req_data_byte == CH_NL;
      tok.body_win = !req_last_byte && (pos_inc < MAX_W)
                     && (pos_ff >= (mlen_w + POS_W'(1)));
   end

   assign len = tok.in_range ? pos_inc[POS_W-1:0] : pos_ff;

   always_comb begin
      pos_in = pos_ff;
      if (mid_push) begin
         pos_in = req_last_byte ? '0 : len;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
      end else begin
         pos_ff <= pos_in;
      end
   end

endmodule

// ===== hdl/hrlm_fifo.sv =====
module hrlm_fifo import hrlm_pkg::*; #(
   parameter int WIDTH = 8,
   parameter int DEPTH = DEF_MID_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wdata,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] rdata,
   output logic             empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = count_ff == CNT_W'(DEPTH);
   assign empty   = count_ff == '0;
   assign do_push = push & ~full;
   assign do_pop  = pop & ~empty;
   assign rdata   = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= wdata;
      end
   end

endmodule

// ===== hdl/hrlm_back.sv =====
`include "http_request_line_matcher_defines.svh"

module hrlm_back import hrlm_pkg::*; #(
   parameter int MAX_PAYLOAD = DEF_MAX_PAYLOAD,
   localparam int POS_W = $clog2(MAX_PAYLOAD + 1)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             mid_empty,
   input  tok_type          tok,
   input  logic [POS_W-1:0] len,
   output logic             mid_pop,
   input  logic             out_full,
   output logic             out_push,
   output rsp_type          rsp
);

   phase_type        phase_ff, phase_in;
   logic             mismatch_ff, mismatch_in;
   logic             wild_ff, wild_in;
   logic [POS_W-1:0] path_count_ff, path_count_in;
   logic             nl1_ff, nl1_in;
   logic             nl2_ff, nl2_in;
   logic             body_seen_ff, body_seen_in;
   logic [POS_W-1:0] body_start_ff, body_start_in;
   logic             ok, body;

   // Hold a last item until the result queue has room.
   assign mid_pop  = !mid_empty && (!tok.last || !out_full);
   assign out_push = mid_pop && tok.last;

   always_comb begin
      phase_in      = phase_ff;
      mismatch_in   = mismatch_ff;
      wild_in       = wild_ff;
      path_count_in = path_count_ff;
      nl1_in        = nl1_ff;
      nl2_in        = nl2_ff;
      body_seen_in  = body_seen_ff;
      body_start_in = body_start_ff;
      if (tok.in_range) begin
         priority if (tok.at_head) begin
            mismatch_in = mismatch_ff | tok.meth_bad;
         end else if (tok.at_space) begin
            mismatch_in = mismatch_ff | tok.sp_bad;
            phase_in    = PH_PATH;
         end else if (phase_ff == PH_PATH) begin
            if (tok.is_term) begin
               mismatch_in = mismatch_ff | !tok.p_zero;
               phase_in    = PH_REST;
            end else begin
               path_count_in = path_count_ff + POS_W'(1);
               wild_in       = wild_ff | tok.p_hash;
               if (!tok.p_qmark && !wild_in && tok.b_ne_p) begin
                  mismatch_in = 1'b1;
               end
            end
         end else begin
         end
         if (tok.body_win && !body_seen_ff && tok.is_nl && (nl1_ff || nl2_ff)) begin
            body_seen_in  = 1'b1;
            body_start_in = len;
         end
         // A path terminator is never a newline, so the flag tracks the kept byte.
         nl2_in = nl1_ff;
         nl1_in = tok.is_nl;
      end
   end

   assign ok   = !mismatch_in && (phase_in != PH_HEAD);
   assign body = ok && body_seen_ff;

   always_comb begin
      rsp.matched     = ok;
      rsp.path_length = OUT_W'(path_count_in);
      rsp.body_found  = body;
      rsp.body_offset = body ? OUT_W'(body_start_ff) : '0;
      rsp.body_length = body ? OUT_W'(len - body_start_ff) : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_HEAD;
         mismatch_ff   <= 1'b0;
         wild_ff       <= 1'b0;
         path_count_ff <= '0;
         nl1_ff        <= 1'b0;
         nl2_ff        <= 1'b0;
         body_seen_ff  <= 1'b0;
         body_start_ff <= '0;
      end else if (mid_pop) begin
         if (tok.last) begin
            phase_ff      <= PH_HEAD;
            mismatch_ff   <= 1'b0;
            wild_ff       <= 1'b0;
            path_count_ff <= '0;
            nl1_ff        <= 1'b0;
            nl2_ff        <= 1'b0;
            body_seen_ff  <= 1'b0;
            body_start_ff <= '0;
         end else begin
            phase_ff      <= phase_in;
            mismatch_ff   <= mismatch_in;
            wild_ff       <= wild_in;
            path_count_ff <= path_count_in;
            nl1_ff        <= nl1_in;
            nl2_ff        <= nl2_in;
            body_seen_ff  <= body_seen_in;
            body_start_ff <= body_start_in;
         end
      end
   end

   `HRLM_ASSERT_NEXT(a_clear_after_last, clock, reset, mid_pop && tok.last, (phase_ff == PH_HEAD) && (path_count_ff == '0) && !body_seen_ff, "state not cleared after last item")
   `HRLM_ASSERT_NOW(a_body_after_head, clock, reset, body_seen_ff, phase_ff != PH_HEAD, "body start seen during method phase")
   `HRLM_ASSERT_NOW(a_path_after_head, clock, reset, (path_count_ff != '0) || wild_ff, phase_ff != PH_HEAD, "path state set during method phase")
   `HRLM_ASSERT_NOW(a_no_push_full, clock, reset, out_push, !out_full, "result pushed into full queue")

endmodule

// ===== hdl/http_request_line_matcher.sv =====
// A result goes from the mid queue through the state update and the result queue
// to the rsp_ ports, and is held back while the result queue is full.
// Throughput: one byte per cycle, through the classify stage and the state update.
// The only stall comes from the result queue filling while rsp_pop stays low.
// Reset (synchronous, active high) restores the default registers, clears the match
// state and empties both queues; no clearing pass follows.
module http_request_line_matcher import hrlm_pkg::*; #(
   parameter int MAX_PAYLOAD = DEF_MAX_PAYLOAD,
   parameter int MID_DEPTH   = DEF_MID_DEPTH,
   parameter int OUT_DEPTH   = DEF_OUT_DEPTH
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_push,
   output logic                  req_full,
   input  logic [7:0]            req_data_byte,
   input  logic                  req_last_byte,
   output logic                  rsp_empty,
   input  logic                  rsp_pop,
   output logic                  rsp_matched,
   output logic [OUT_W-1:0]      rsp_path_length,
   output logic                  rsp_body_found,
   output logic [OUT_W-1:0]      rsp_body_offset,
   output logic [OUT_W-1:0]      rsp_body_length,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   localparam int POS_W = $clog2(MAX_PAYLOAD + 1);
   localparam int MID_W = $bits(tok_type) + POS_W;
   localparam int RSP_W = $bits(rsp_type);

   cfg_type          cfg;
   tok_type          front_tok, back_tok;
   logic [POS_W-1:0] front_len, back_len;
   logic             mid_push, mid_full, mid_pop, mid_empty;
   logic [MID_W-1:0] mid_rdata;
   logic             out_push, out_full;
   rsp_type          back_rsp, out_rsp;
   logic [RSP_W-1:0] out_rdata;

   hrlm_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   hrlm_front #(.MAX_PAYLOAD(MAX_PAYLOAD)) u_front (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg),
      .req_push      (req_push),
      .req_full      (req_full),
      .req_data_byte (req_data_byte),
      .req_last_byte (req_last_byte),
      .mid_full      (mid_full),
      .mid_push      (mid_push),
      .tok           (front_tok),
      .len           (front_len)
   );

   hrlm_fifo #(.WIDTH(MID_W), .DEPTH(MID_DEPTH)) u_mid_fifo (
      .clock (clock),
      .reset (reset),
      .push  (mid_push),
      .wdata ({front_tok, front_len}),
      .full  (mid_full),
      .pop   (mid_pop),
      .rdata (mid_rdata),
      .empty (mid_empty)
   );

   assign back_tok = tok_type'(mid_rdata[MID_W-1:POS_W]);
   assign back_len = mid_rdata[POS_W-1:0];

   hrlm_back #(.MAX_PAYLOAD(MAX_PAYLOAD)) u_back (
      .clock     (clock),
      .reset     (reset),
      .mid_empty (mid_empty),
      .tok       (back_tok),
      .len       (back_len),
      .mid_pop   (mid_pop),
      .out_full  (out_full),
      .out_push  (out_push),
      .rsp       (back_rsp)
   );

   hrlm_fifo #(.WIDTH(RSP_W), .DEPTH(OUT_DEPTH)) u_out_fifo (
      .clock (clock),
      .reset (reset),
      .push  (out_push),
      .wdata (back_rsp),
      .full  (out_full),
      .pop   (rsp_pop),
      .rdata (out_rdata),
      .empty (rsp_empty)
   );

   assign out_rsp         = rsp_type'(out_rdata);
   assign rsp_matched     = out_rsp.matched;
   assign rsp_path_length = out_rsp.path_length;
   assign rsp_body_found  = out_rsp.body_found;
   assign rsp_body_offset = out_rsp.body_offset;
   assign rsp_body_length = out_rsp.body_length;

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top import hrlm_pkg::*; ();

   localparam logic [7:0] CH_CR = 8'h0D;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                  req_push      = 1'b0;
   logic                  req_full;
   logic [7:0]            req_data_byte = '0;
   logic                  req_last_byte = 1'b0;
   logic                  rsp_empty;
   logic                  rsp_pop       = 1'b0;
   logic                  rsp_matched;
   logic [OUT_W-1:0]      rsp_path_length;
   logic                  rsp_body_found;
   logic [OUT_W-1:0]      rsp_body_offset;
   logic [OUT_W-1:0]      rsp_body_length;
   logic                  csr_psel      = 1'b0;
   logic                  csr_penable   = 1'b0;
   logic                  csr_pwrite    = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr     = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata    = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   http_request_line_matcher dut (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_data_byte   (req_data_byte),
      .req_last_byte   (req_last_byte),
      .rsp_empty       (rsp_empty),
      .rsp_pop         (rsp_pop),
      .rsp_matched     (rsp_matched),
      .rsp_path_length (rsp_path_length),
      .rsp_body_found  (rsp_body_found),
      .rsp_body_offset (rsp_body_offset),
      .rsp_body_length (rsp_body_length),
      .csr_psel        (csr_psel),
      .csr_penable     (csr_penable),
      .csr_pwrite      (csr_pwrite),
      .csr_paddr       (csr_paddr),
      .csr_pwdata      (csr_pwdata),
      .csr_prdata      (csr_prdata),
      .csr_pready      (csr_pready)
   );

   always #4 clock = ~clock;

   // Register copies kept by the match predictor.
   logic [63:0]            cfg_chars = RST_METHOD_CHARS;
   logic [3:0]             cfg_len   = RST_METHOD_LEN;
   logic [PAT_BYTES*8-1:0] cfg_pat   = {{(PAT_BYTES*8-64){1'b0}}, RST_PATTERN0};

   // Per-request match state.
   int unsigned st_pos     = 0;
   phase_type   st_phase   = PH_HEAD;
   bit          st_bad     = 1'b0;
   bit          st_wild    = 1'b0;
   int unsigned st_path    = 0;
   logic [7:0]  st_prev    = CH_NUL;
   logic [7:0]  st_prev2   = CH_NUL;
   bit          st_body    = 1'b0;
   int unsigned st_body_at = 0;

   rsp_type     expected_results [$];
   rsp_type     want_rsp;
   logic [7:0]  pkt [$];

   int send_idle_pct = 0;
   int pop_stall_pct = 0;
   int error_count   = 0;
   int bytes_sent    = 0;
   int requests_sent = 0;
   int results_seen  = 0;
   int csr_writes    = 0;

   task automatic report_error(string msg);
      error_count++;
      if (error_count <= 50)
         $display("ERROR at %0t ns: %s", $time, msg);
   endtask

   function automatic logic [7:0] pattern_char(int unsigned i);
      int unsigned j;
      logic [7:0]  c;
      if (i >= PAT_BYTES)
         return CH_NUL;
      c = CH_NUL;
      for (j = 0; j <= i; j++) begin
         c = cfg_pat[8*j +: 8];
         if (c == CH_NUL)
            return CH_NUL;
      end
      return c;
   endfunction

   task automatic predict_byte(logic [7:0] b, logic is_last);
      int unsigned mlen;
      logic [7:0]  keep;
      logic [7:0]  p;
      bit          ok;
      bit          body;
      rsp_type     r;
      mlen = (cfg_len > 8) ? 8 : cfg_len;
      if (st_pos < DEF_MAX_PAYLOAD) begin
         keep = b;
         if (st_pos < mlen) begin
            if (b != cfg_chars[8*st_pos +: 8])
               st_bad = 1'b1;
         end else if (st_pos == mlen) begin
            if (b != CH_SPACE)
               st_bad = 1'b1;
            st_phase = PH_PATH;
         end else if (st_phase == PH_PATH) begin
            p = pattern_char(st_pos - mlen - 1);
            if (b == CH_SPACE || b == CH_TAB || b == CH_QMARK) begin
               // a terminator only matches the end of the pattern
               if (p != CH_NUL)
                  st_bad = 1'b1;
               st_phase = PH_REST;
               keep = CH_NUL;
            end else begin
               st_path++;
               if (p == CH_HASH)
                  st_wild = 1'b1;
               if (p != CH_QMARK && !st_wild && b != p)
                  st_bad = 1'b1;
            end
         end
         if (!is_last && !st_body && st_pos + 1 < DEF_MAX_PAYLOAD && st_pos >= mlen + 1 &&
             b == CH_NL && (st_prev == CH_NL || st_prev2 == CH_NL)) begin
            st_body    = 1'b1;
            st_body_at = st_pos + 1;
         end
         st_prev2 = st_prev;
         st_prev  = keep;
         st_pos++;
      end
      if (is_last) begin
         ok   = !st_bad && st_phase != PH_HEAD;
         body = ok && st_body;
         r.matched     = ok;
         r.path_length = OUT_W'(st_path);
         r.body_found  = body;
         r.body_offset = body ? OUT_W'(st_body_at) : '0;
         r.body_length = body ? OUT_W'(st_pos - st_body_at) : '0;
         expected_results.push_back(r);
         st_pos     = 0;
         st_phase   = PH_HEAD;
         st_bad     = 1'b0;
         st_wild    = 1'b0;
         st_path    = 0;
         st_prev    = CH_NUL;
         st_prev2   = CH_NUL;
         st_body    = 1'b0;
         st_body_at = 0;
      end
   endtask

   task automatic check_field(string name, logic [OUT_W-1:0] got, logic [OUT_W-1:0] want);
      if (got !== want)
         report_error($sformatf("result %0d %s: got %0d, expected %0d",
                                results_seen, name, got, want));
   endtask

   // Check every popped result against the oldest prediction, then pick the next pop.
   always @(posedge clock) begin
      if (!reset && rsp_pop && !rsp_empty) begin
         if (expected_results.size() == 0) begin
            report_error("result popped with no request outstanding");
         end else begin
            want_rsp = expected_results.pop_front();
            check_field("matched", OUT_W'(rsp_matched), OUT_W'(want_rsp.matched));
            check_field("path_length", rsp_path_length, want_rsp.path_length);
            check_field("body_found", OUT_W'(rsp_body_found), OUT_W'(want_rsp.body_found));
            check_field("body_offset", rsp_body_offset, want_rsp.body_offset);
            check_field("body_length", rsp_body_length, want_rsp.body_length);
         end
         results_seen++;
      end
      rsp_pop <= ($urandom_range(99) >= pop_stall_pct);
   end

   task automatic send_byte(logic [7:0] b, logic is_last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push      <= 1'b1;
      req_data_byte <= b;
      req_last_byte <= is_last;
      do @(posedge clock); while (req_full);
      bytes_sent++;
      predict_byte(b, is_last);
   endtask

   task automatic send_request();
      foreach (pkt[i])
         send_byte(pkt[i], i == pkt.size() - 1);
      requests_sent++;
   endtask

   task automatic add_str(string s);
      for (int i = 0; i < s.len(); i++)
         pkt.push_back(s[i]);
   endtask

   task automatic new_pkt(string s);
      pkt.delete();
      add_str(s);
   endtask

   task automatic end_line();
      if ($urandom_range(1))
         pkt.push_back(CH_CR);
      pkt.push_back(CH_NL);
   endtask

   function automatic logic [PAT_BYTES*8-1:0] pack_text(string s);
      logic [PAT_BYTES*8-1:0] v;
      v = '0;
      for (int i = 0; i < s.len() && i < PAT_BYTES; i++)
         v[8*i +: 8] = s[i];
      return v;
   endfunction

   function automatic logic [7:0] path_char();
      logic [7:0] c;
      do begin
         if ($urandom_range(3) == 0)
            c = 8'($urandom_range(255));
         else
            c = 8'($urandom_range(8'h61, 8'h7A));
      end while (c == CH_SPACE || c == CH_TAB || c == CH_QMARK);
      return c;
   endfunction

   // Hold off until every result is back and the pipeline is empty.
   task automatic drain();
      req_push <= 1'b0;
      while (expected_results.size() != 0)
         @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   task automatic csr_write(reg_idx_type idx, logic [63:0] value);
      logic [63:0] back;
      logic [63:0] mask;
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_ADDR_W'({idx, 3'b000});
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      case (idx)
         REG_METHOD_CHARS: cfg_chars = value;
         REG_METHOD_LEN:   cfg_len = value[3:0];
         REG_PATTERN0:     cfg_pat[0 +: 64] = value;
         REG_PATTERN1:     cfg_pat[64 +: 64] = value;
         REG_PATTERN2:     cfg_pat[128 +: 64] = value;
         REG_PATTERN3:     cfg_pat[192 +: 64] = value;
         default: ;
      endcase
      csr_writes++;
      // read the register back
      csr_pwrite  <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      back = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
      mask = (idx == REG_METHOD_LEN) ? 64'hF : '1;
      if ((back & mask) !== (value & mask))
         report_error($sformatf("register %s read back %h, wrote %h", idx.name(), back, value));
   endtask

   task automatic set_config(logic [63:0] chars, logic [3:0] len, logic [PAT_BYTES*8-1:0] pat);
      logic [63:0] v;
      drain();
      csr_write(REG_METHOD_CHARS, chars);
      v = {$urandom, $urandom};
      v[3:0] = len;
      csr_write(REG_METHOD_LEN, v);
      csr_write(REG_PATTERN0, pat[0 +: 64]);
      csr_write(REG_PATTERN1, pat[64 +: 64]);
      csr_write(REG_PATTERN2, pat[128 +: 64]);
      csr_write(REG_PATTERN3, pat[192 +: 64]);
   endtask

   // Runs on the reset register values: method GET, pattern "/".
   task automatic test_request_basics();
      new_pkt("GET / HTTP/1.1\015\nHost: a\015\n\015\nhi");
      send_request();
      new_pkt("GET /");
      send_request();
      new_pkt("GET ");
      send_request();
      new_pkt("GE");
      send_request();
      new_pkt("GET /x HTTP/1.1\n\nz");
      send_request();
      new_pkt("PUT / HTTP\n\nz");
      send_request();
      new_pkt("GETX/ ");
      send_request();
      new_pkt("G");
      send_request();
      new_pkt("GET /\t\n\nab");
      send_request();
      new_pkt("GET /?\n\nq");
      send_request();
      new_pkt("GET / x\n\n");
      send_request();
      new_pkt("GET / \n\n");
      send_request();
      new_pkt("GET /\n\nX");
      send_request();
      new_pkt("GET / a\nb\nc");
      send_request();
      pkt = {CH_NUL};
      send_request();
      pkt = {8'hFF, CH_NUL};
      send_request();
   endtask

   task automatic test_method_lengths();
      logic [63:0] chars [4];
      logic [3:0]  lens [4];
      int unsigned mlen;
      int unsigned k;
      chars[0] = {$urandom, $urandom};
      chars[1] = '0;
      chars[2] = '1;
      chars[3] = pack_text("ABCDEFGH");
      lens = '{4'd0, 4'd1, 4'd8, 4'd15};
      for (int t = 0; t < 4; t++) begin
         set_config(chars[t], lens[t], pack_text("/"));
         mlen = (lens[t] > 8) ? 8 : lens[t];
         pkt.delete();
         for (k = 0; k < mlen; k++)
            pkt.push_back(chars[t][8*k +: 8]);
         add_str(" /\n\nok");
         send_request();
         // wrong final method character
         pkt.delete();
         for (k = 0; k < mlen; k++)
            pkt.push_back(chars[t][8*k +: 8]);
         add_str(" /");
         if (mlen > 0)
            pkt[mlen-1] = pkt[mlen-1] ^ 8'h01;
         send_request();
         // method followed by something other than a space
         pkt.delete();
         for (k = 0; k < mlen; k++)
            pkt.push_back(chars[t][8*k +: 8]);
         add_str("x/");
         send_request();
         // payload ends inside the method
         if (mlen > 0) begin
            pkt.delete();
            for (k = 0; k < mlen; k++)
               pkt.push_back(chars[t][8*k +: 8]);
            send_request();
         end
      end
   endtask

   task automatic test_path_patterns();
      logic [PAT_BYTES*8-1:0] pat;
      set_config(RST_METHOD_CHARS, RST_METHOD_LEN, pack_text("/a?c#"));
      new_pkt("GET /abcdef HTTP/1.1\n\nB");
      send_request();
      new_pkt("GET /aZcQ");
      send_request();
      new_pkt("GET /abd x");
      send_request();
      new_pkt("GET /ab x");
      send_request();
      new_pkt("GET /abc x");
      send_request();
      new_pkt("GET /a");
      send_request();
      // bytes after the first zero must be ignored
      pat = pack_text("/x");
      pat[24 +: 40] = 40'h5A5A5A5A5A;
      pat[64 +: 64] = {$urandom, $urandom};
      set_config(RST_METHOD_CHARS, RST_METHOD_LEN, pat);
      new_pkt("GET /x y\n\nz");
      send_request();
      new_pkt("GET /xZ ");
      send_request();
      // pattern fills all 32 bytes
      set_config(RST_METHOD_CHARS, RST_METHOD_LEN, {PAT_BYTES{8'h61}});
      new_pkt("GET ");
      repeat (32) pkt.push_back(8'h61);
      add_str(" \n\nb");
      send_request();
      new_pkt("GET ");
      repeat (33) pkt.push_back(8'h61);
      add_str(" ");
      send_request();
      new_pkt("GET ");
      repeat (32) pkt.push_back(8'h61);
      send_request();
      new_pkt("GET ");
      repeat (40) pkt.push_back(8'h61);
      send_request();
      // empty pattern
      set_config(RST_METHOD_CHARS, RST_METHOD_LEN, '0);
      new_pkt("GET ?\n\nb");
      send_request();
      new_pkt("GET /");
      send_request();
   endtask

   task automatic test_long_payloads();
      // wildcard path past the kept window, blank line right at its end
      set_config(RST_METHOD_CHARS, RST_METHOD_LEN, pack_text("/#"));
      new_pkt("GET /");
      while (pkt.size() < DEF_MAX_PAYLOAD + 2)
         pkt.push_back(8'h61);
      pkt[DEF_MAX_PAYLOAD - 3] = CH_NL;
      pkt[DEF_MAX_PAYLOAD - 2] = CH_NL;
      send_request();
   endtask

   task automatic build_request();
      int unsigned mlen;
      int unsigned k;
      logic [7:0]  p;
      pkt.delete();
      mlen = (cfg_len > 8) ? 8 : cfg_len;
      for (k = 0; k < mlen; k++)
         pkt.push_back(cfg_chars[8*k +: 8]);
      pkt.push_back(CH_SPACE);
      for (k = 0; k < PAT_BYTES; k++) begin
         p = pattern_char(k);
         if (p == CH_NUL)
            break;
         if (p == CH_HASH) begin
            repeat ($urandom_range(0, 8)) pkt.push_back(path_char());
            break;
         end
         pkt.push_back(p == CH_QMARK ? path_char() : p);
      end
      if ($urandom_range(9) != 0) begin
         case ($urandom_range(2))
            0: pkt.push_back(CH_SPACE);
            1: pkt.push_back(CH_TAB);
            default: pkt.push_back(CH_QMARK);
         endcase
         add_str("HTTP/1.1");
         end_line();
         repeat ($urandom_range(0, 2)) begin
            add_str("Hdr: v");
            end_line();
         end
         if ($urandom_range(4) != 0)
            end_line();
         repeat ($urandom_range(0, 8)) pkt.push_back(8'($urandom_range(255)));
      end
      if ($urandom_range(9) == 0)
         pkt[$urandom_range(pkt.size() - 1)] = 8'($urandom_range(255));
   endtask

   function automatic logic [PAT_BYTES*8-1:0] random_pattern(int unsigned n);
      logic [PAT_BYTES*8-1:0] pat;
      int unsigned r;
      pat = '0;
      for (int unsigned k = 0; k < PAT_BYTES; k++) begin
         r = $urandom_range(99);
         if (k < n) begin
            if (r < 12)
               pat[8*k +: 8] = CH_QMARK;
            else if (r < 17)
               pat[8*k +: 8] = CH_HASH;
            else if (r < 22)
               pat[8*k +: 8] = 8'($urandom_range(1, 255));
            else if (r < 40)
               pat[8*k +: 8] = 8'h2F;
            else
               pat[8*k +: 8] = 8'($urandom_range(8'h61, 8'h7A));
         end else if (k > n && r < 30) begin
            pat[8*k +: 8] = 8'($urandom_range(1, 255));
         end
      end
      return pat;
   endfunction

   task automatic run_phase(int kind, int s_idle, int p_stall);
      logic [63:0]            chars;
      logic [3:0]             len;
      logic [PAT_BYTES*8-1:0] pat;
      int                     b0;
      int                     r0;
      case (kind)
         0: begin
            for (int k = 0; k < 8; k++)
               chars[8*k +: 8] = 8'($urandom_range(8'h41, 8'h5A));
            len = 4'($urandom_range(1, 8));
            pat = random_pattern($urandom_range(0, 12));
         end
         1: begin
            chars = '1;
            len   = 4'd15;
            pat   = random_pattern(PAT_BYTES);
         end
         2: begin
            chars = {$urandom, $urandom};
            len   = 4'd0;
            pat   = random_pattern(0);
         end
         default: begin
            chars = '0;
            len   = 4'd8;
            pat   = random_pattern($urandom_range(1, 4));
         end
      endcase
      set_config(chars, len, pat);
      send_idle_pct = s_idle;
      pop_stall_pct = p_stall;
      b0 = bytes_sent;
      r0 = requests_sent;
      while (bytes_sent - b0 < 16 || requests_sent - r0 < 1) begin
         if ($urandom_range(99) < 80) begin
            build_request();
         end else begin
            pkt.delete();
            repeat ($urandom_range(1, 16))
               pkt.push_back(($urandom_range(7) == 0) ? CH_NL : 8'($urandom_range(255)));
         end
         send_request();
      end
   endtask

   task automatic test_random_traffic();
      int send_mix [4];
      int pop_mix [4];
      send_mix = '{0, 71, 0, 17};
      pop_mix  = '{0, 0, 71, 17};
      for (int m = 0; m < 4; m++)
         for (int c = 0; c < 3; c++)
            run_phase((m * 3 + c) % 4, send_mix[m], pop_mix[m]);
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      test_request_basics();
      test_method_lengths();
      test_path_patterns();
      test_long_payloads();
      test_random_traffic();
      drain();
      $display("Run covered %0d requests (%0d bytes), %0d results checked, %0d register writes",
               requests_sent, bytes_sent, results_seen, csr_writes);
      $display("Mix: method lengths 0 to 15, wildcard and full-width paths, oversize payloads");
      if (error_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

   initial begin
      #2_000_000;
      $display("Timeout: results still outstanding: %0d", expected_results.size());
      $display("DONE: errors detected");
      $finish;
   end

endmodule
